[src/cdda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Shared widths, status codes, request/response types of the year unit and
// the month tables of the Gregorian calendar.
// ----------------------------------------------------------------------------
package cdda_pkg;

	// Years inside the block reach a little past the largest input year.
	localparam int YEAR_W = 13;
	// Unsigned day count from 1 Jan of year 0.
	localparam int SER_W = 21;
	// Signed serial numbers and day differences.
	localparam int DIFF_W = 22;
	// Day remainder inside one year.
	localparam int REST_W = 9;

	// Stream payload widths.
	localparam int IN_TDATA_W = 64;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_TUSER_W = 2;

	// Reciprocal of 100 scaled by two to the RECIP_SHIFT; exact for 13-bit years.
	localparam int RECIP_100 = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W = 2 * YEAR_W;
	localparam int Q100_W = 7;

	// Result status codes.
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	// Request to the year unit.
	typedef struct packed {
		logic              start;
		logic [YEAR_W-1:0] year;
	} yu_req_t;

	// Response of the year unit: days before 1 Jan of the year and its leap flag.
	typedef struct packed {
		logic             done;
		logic [SER_W-1:0] dby;
		logic             leap;
	} yu_rsp_t;

	// Length of a month, zero for a month code outside 1 to 12.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
			4'd2:                                        d = leap ? 5'd29 : 5'd28;
			default:                                     d = 5'd0;
		endcase
		return d;
	endfunction

	// Days from 1 Jan to the first of the month, the month clamped into 1 to 12.
	function automatic logic [REST_W-1:0] days_before_month(input logic [3:0] m,
		input logic leap);
		logic [REST_W-1:0] s;
		case (m)
			4'd0, 4'd1: s = 9'd0;
			4'd2:       s = 9'd31;
			4'd3:       s = 9'd59;
			4'd4:       s = 9'd90;
			4'd5:       s = 9'd120;
			4'd6:       s = 9'd151;
			4'd7:       s = 9'd181;
			4'd8:       s = 9'd212;
			4'd9:       s = 9'd243;
			4'd10:      s = 9'd273;
			4'd11:      s = 9'd304;
			default:    s = 9'd334;
		endcase
		if (leap && m > 4'd2) begin
			s = s + 9'd1;
		end
		return s;
	endfunction

endpackage

[src/cdda_year_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date year unit
// Three-stage pipeline that gives the number of days before 1 Jan of a year
// and whether that year is a leap year, using a reciprocal multiply for the
// century quotient.
// ----------------------------------------------------------------------------
module cdda_year_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  cdda_pkg::yu_req_t req,
	output cdda_pkg::yu_rsp_t rsp
);
	import cdda_pkg::*;

	logic              vld_s1, vld_s2, vld_s3;
	logic [YEAR_W-1:0] y_s1, y_s2;
	logic [Q100_W-1:0] q100_s1, q100_s2;
	logic [Q100_W-1:0] r100_s2;
	logic [PROD_W-1:0] prod;
	logic [YEAR_W-1:0] hund;
	logic [YEAR_W-1:0] y_plus3;
	logic              nz100, nz400;
	logic [SER_W-1:0]  dby_s3;
	logic              leap_s3;
	logic [SER_W-1:0]  dby_next;

	// Valid flags travel with the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: century quotient by reciprocal multiplication.
	assign prod = PROD_W'(req.year) * PROD_W'(RECIP_100);

	always_ff @(posedge clk) begin
		y_s1    <= req.year;
		q100_s1 <= prod[RECIP_SHIFT +: Q100_W];
	end

	// Stage 2: remainder of the year by 100.
	assign hund = YEAR_W'(q100_s1) * YEAR_W'(100);

	always_ff @(posedge clk) begin
		y_s2    <= y_s1;
		q100_s2 <= q100_s1;
		r100_s2 <= Q100_W'(y_s1 - hund);
	end

	// Stage 3: day count with ceiling quotients by 4, 100 and 400.
	assign nz100   = (r100_s2 != '0);
	assign nz400   = nz100 || (q100_s2[1:0] != 2'd0);
	assign y_plus3 = y_s2 + YEAR_W'(3);
	assign dby_next = SER_W'(y_s2) * SER_W'(365)
		+ SER_W'(y_plus3 >> 2)
		- SER_W'(q100_s2) - SER_W'(nz100)
		+ SER_W'(q100_s2 >> 2) + SER_W'(nz400);

	always_ff @(posedge clk) begin
		dby_s3  <= dby_next;
		leap_s3 <= (y_s2[1:0] == 2'd0) && (nz100 || (q100_s2[1:0] == 2'd0));
	end

	assign rsp = '{done: vld_s3, dby: dby_s3, leap: leap_s3};

endmodule

[src/calendar_date_day_arithmetic_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date day arithmetic
// Validates a Gregorian base date, shifts it by a signed day offset and gives
// the signed day difference to a second date with later and equal flags.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. The input is accepted only when the
// sequencer is idle, and the result waits in an output register, so a new
// transaction can enter while the previous result is still unread. An invalid
// base date ends the transaction after the two year lookups. Otherwise the
// shifted date is found by walking years one at a time through the
// three-stage year unit (at most about 180 years for the largest offset),
// followed by up to eleven month steps.
module calendar_date_day_arithmetic_top #(
	parameter int MAX_YEAR = 4095
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// base_year[11:0], base_month[15:12], base_day[20:16], day_offset[37:21],
	// other_year[49:38], other_month[53:50], other_day[58:54], zero fill above
	input  logic [cdda_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// result_year[11:0], result_month[15:12], result_day[20:16],
	// days_between[42:21], base_later[43], dates_equal[44], zero fill above
	output logic [cdda_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// status[1:0]
	output logic [cdda_pkg::OUT_TUSER_W-1:0]    m_tuser
);
	import cdda_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BASE  = 3'd1;
	localparam logic [2:0] ST_OTHER = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_UP    = 3'd4;
	localparam logic [2:0] ST_DOWN  = 3'd5;
	localparam logic [2:0] ST_MONTH = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]               state_q;
	yu_req_t                  req;
	yu_rsp_t                  rsp;
	logic                     req_start_q;
	logic [YEAR_W-1:0]        req_year_q;

	logic [11:0]              by_q, oy_q;
	logic [3:0]               bm_q, om_q;
	logic [4:0]               bd_q, od_q;
	logic signed [16:0]       off_q;
	logic signed [DIFF_W-1:0] bs_q, diff_q, s_q;
	logic                     bad_q;
	logic [YEAR_W-1:0]        y_q;
	logic                     leap_q;
	logic [REST_W-1:0]        rest_q;
	logic [3:0]               m_q;
	logic [1:0]               status_q;

	logic                     m_tvalid_q;
	logic [OUT_TDATA_W-1:0]   out_data_q;
	logic [OUT_TUSER_W-1:0]   out_user_q;

	logic signed [DIFF_W-1:0] dby_s;
	logic signed [DIFF_W-1:0] serial_now;
	logic signed [DIFF_W-1:0] shifted;
	logic [4:0]               dim_base;
	logic [4:0]               dim_walk;
	logic                     base_bad;
	logic                     later, equal;
	logic                     ok_fin;
	logic                     step_down;
	logic [20:0]              date_bits;

	// Shared year unit.
	assign req = '{start: req_start_q, year: req_year_q};

	cdda_year_unit u_year (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Serial number of whichever date the year unit has just finished.
	assign dby_s = DIFF_W'(rsp.dby);
	always_comb begin
		if (state_q == ST_BASE) begin
			serial_now = dby_s + DIFF_W'(days_before_month(bm_q, rsp.leap))
				+ DIFF_W'(bd_q) - DIFF_W'(1);
		end else begin
			serial_now = dby_s + DIFF_W'(days_before_month(om_q, rsp.leap))
				+ DIFF_W'(od_q) - DIFF_W'(1);
		end
	end

	// Base date check.
	assign dim_base = month_days(bm_q, rsp.leap);
	assign base_bad = (32'(by_q) > MAX_YEAR) || (bd_q == 5'd0) || (bd_q > dim_base);

	assign shifted  = bs_q + DIFF_W'(off_q);
	assign dim_walk = month_days(m_q, leap_q);

	// The downward year walk continues while the candidate year starts after the target.
	assign step_down = (y_q != '0) && (dby_s > s_q);

	// Raw field compare flags.
	assign equal = (by_q == oy_q) && (bm_q == om_q) && (bd_q == od_q);
	assign later = (by_q > oy_q) || ((by_q == oy_q) &&
		((bm_q > om_q) || ((bm_q == om_q) && (bd_q > od_q))));

	assign ok_fin = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_start_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					req_start_q <= s_tvalid;
					if (s_tvalid) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					req_start_q <= rsp.done;
					if (rsp.done) begin
						state_q <= ST_OTHER;
					end
				end
				ST_OTHER: begin
					req_start_q <= 1'b0;
					if (rsp.done) begin
						state_q <= bad_q ? ST_FIN : ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					req_start_q <= !shifted[DIFF_W-1];
					if (shifted[DIFF_W-1]) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_UP;
					end
				end
				ST_UP: begin
					req_start_q <= rsp.done;
					if (rsp.done && dby_s > s_q) begin
						state_q <= ST_DOWN;
					end
				end
				ST_DOWN: begin
					req_start_q <= rsp.done && step_down;
					if (rsp.done && !step_down) begin
						if (32'(y_q) > MAX_YEAR) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_MONTH;
						end
					end
				end
				ST_MONTH: begin
					req_start_q <= 1'b0;
					if (!(m_q < 4'd12 && rest_q >= REST_W'(dim_walk))) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					req_start_q <= 1'b0;
					if (ok_fin) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					req_start_q <= 1'b0;
					state_q     <= ST_IDLE;
				end
			endcase
		end
	end

	// Sequencer data path.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				by_q       <= s_tdata[11:0];
				bm_q       <= s_tdata[15:12];
				bd_q       <= s_tdata[20:16];
				off_q      <= s_tdata[37:21];
				oy_q       <= s_tdata[49:38];
				om_q       <= s_tdata[53:50];
				od_q       <= s_tdata[58:54];
				req_year_q <= YEAR_W'(s_tdata[11:0]);
			end
			ST_BASE: begin
				if (rsp.done) begin
					bs_q       <= serial_now;
					bad_q      <= base_bad;
					req_year_q <= YEAR_W'(oy_q);
				end
			end
			ST_OTHER: begin
				if (rsp.done) begin
					diff_q   <= bs_q - serial_now;
					status_q <= bad_q ? STATUS_BAD_DATE : STATUS_OK;
				end
			end
			ST_SHIFT: begin
				s_q        <= shifted;
				y_q        <= YEAR_W'(by_q);
				req_year_q <= YEAR_W'(by_q) + YEAR_W'(1);
				if (shifted[DIFF_W-1]) begin
					status_q <= STATUS_RANGE;
				end
			end
			ST_UP: begin
				if (rsp.done) begin
					if (dby_s > s_q) begin
						req_year_q <= y_q;
					end else begin
						y_q        <= y_q + YEAR_W'(1);
						req_year_q <= y_q + YEAR_W'(2);
					end
				end
			end
			ST_DOWN: begin
				if (rsp.done) begin
					if (step_down) begin
						y_q        <= y_q - YEAR_W'(1);
						req_year_q <= y_q - YEAR_W'(1);
					end else if (32'(y_q) > MAX_YEAR) begin
						status_q <= STATUS_RANGE;
					end else begin
						rest_q <= REST_W'(s_q - dby_s);
						leap_q <= rsp.leap;
						m_q    <= 4'd1;
					end
				end
			end
			ST_MONTH: begin
				if (m_q < 4'd12 && rest_q >= REST_W'(dim_walk)) begin
					rest_q <= rest_q - REST_W'(dim_walk);
					m_q    <= m_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ok_fin) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Date fields are cleared unless the shift succeeded.
	assign date_bits = (status_q == STATUS_OK) ? {rest_q[4:0] + 5'd1, m_q, y_q[11:0]} : '0;

	always_ff @(posedge clk) begin
		if (ok_fin) begin
			out_data_q <= OUT_TDATA_W'({equal, later, diff_q, date_bits});
			out_user_q <= status_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`ifndef SYNTHESIS
	// The year unit only answers while the sequencer waits for it.
	a_unit_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == ST_BASE || state_q == ST_OTHER ||
			state_q == ST_UP || state_q == ST_DOWN))
		else $error("year unit answered outside a wait state");

	// The month walk stays within the calendar.
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MONTH |-> (m_q >= 4'd1 && m_q <= 4'd12))
		else $error("month walk left the range 1 to 12");

	// A good result carries a real month and day.
	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && m_tuser == STATUS_OK |->
			(m_tdata[15:12] != 4'd0 && m_tdata[20:16] != 5'd0))
		else $error("good result with empty month or day");
`endif

endmodule

[bench/calendar_date_day_arithmetic_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date day arithmetic testbench
// Sends date transactions through the input stream and checks each result
// against a behavioral model of Gregorian date shifting and day counting,
// with random source bursts and sink stalls on the two stream interfaces.
// ----------------------------------------------------------------------------
module calendar_date_day_arithmetic_top_tb;

	localparam int MAX_YEAR = 4095;
	// Idle limit covers the slowest transaction plus sink stall and source gap.
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 800;
	localparam int RANDOM_ITEMS = 117;
	localparam int REPORT_MAX = 10;

	// Fields of one input transaction.
	typedef struct packed {
		logic [11:0]        base_year;
		logic [3:0]         base_month;
		logic [4:0]         base_day;
		logic signed [16:0] day_offset;
		logic [11:0]        other_year;
		logic [3:0]         other_month;
		logic [4:0]         other_day;
	} date_req_t;

	// Fields of one result transaction.
	typedef struct packed {
		logic [11:0]        result_year;
		logic [3:0]         result_month;
		logic [4:0]         result_day;
		logic signed [21:0] days_between;
		logic               base_later;
		logic               dates_equal;
		logic [1:0]         status;
	} date_rsp_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 s_tvalid;
	logic                                 s_tready;
	logic [cdda_pkg::IN_TDATA_W-1:0]      s_tdata;
	logic                                 m_tvalid;
	logic                                 m_tready;
	logic [cdda_pkg::OUT_TDATA_W-1:0]     m_tdata;
	logic [cdda_pkg::OUT_TUSER_W-1:0]     m_tuser;

	date_rsp_t pending_results[$];
	int        error_count;
	int        burst_left;

	calendar_date_day_arithmetic_top #(
		.MAX_YEAR(MAX_YEAR)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = ~clk;
		end
	end

	// ------------------------------------------------------------------------
	// Calendar model
	// ------------------------------------------------------------------------

	function automatic bit leap_year(input longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// Zero for a month code outside 1 to 12.
	function automatic int month_length(input longint y, input int m);
		int len;
		case (m)
			1, 3, 5, 7, 8, 10, 12: len = 31;
			4, 6, 9, 11:           len = 30;
			2:                     len = leap_year(y) ? 29 : 28;
			default:               len = 0;
		endcase
		return len;
	endfunction

	// Days from 1 Jan of year 0 to 1 Jan of year y.
	function automatic longint year_start(input longint y);
		if (y <= 0) begin
			return 0;
		end
		return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	// Days from 1 Jan to the first of the month, the month clamped into 1 to 12.
	function automatic longint month_start(input longint y, input int m);
		longint sum;
		int     mc;
		sum = 0;
		mc = (m < 1) ? 1 : ((m > 12) ? 12 : m);
		for (int k = 1; k < mc; k++) begin
			sum += month_length(y, k);
		end
		return sum;
	endfunction

	function automatic longint day_number(input longint y, input int m, input int d);
		return year_start(y) + month_start(y, m) + d - 1;
	endfunction

	// Expected result of one date transaction.
	function automatic date_rsp_t predict_date_result(input date_req_t r);
		date_rsp_t p;
		longint    base_num;
		longint    shifted;
		longint    yr;
		longint    rest;
		int        mo;
		int        by;
		int        bm;
		int        bd;
		int        oy;
		int        om;
		int        od;
		p = '0;
		by = r.base_year;
		bm = r.base_month;
		bd = r.base_day;
		oy = r.other_year;
		om = r.other_month;
		od = r.other_day;
		base_num = day_number(by, bm, bd);
		p.days_between = 22'(base_num - day_number(oy, om, od));
		p.status = cdda_pkg::STATUS_OK;
		if (by > MAX_YEAR || bm < 1 || bm > 12 || bd < 1 || bd > month_length(by, bm)) begin
			p.status = cdda_pkg::STATUS_BAD_DATE;
		end else begin
			shifted = base_num + longint'(r.day_offset);
			if (shifted < 0) begin
				p.status = cdda_pkg::STATUS_RANGE;
			end else begin
				yr = (shifted * 400) / 146097;
				while (year_start(yr + 1) <= shifted) begin
					yr++;
				end
				while (yr > 0 && year_start(yr) > shifted) begin
					yr--;
				end
				if (yr > MAX_YEAR) begin
					p.status = cdda_pkg::STATUS_RANGE;
				end else begin
					rest = shifted - year_start(yr);
					mo = 1;
					while (mo < 12 && rest >= month_length(yr, mo)) begin
						rest -= month_length(yr, mo);
						mo++;
					end
					p.result_year = 12'(yr);
					p.result_month = 4'(mo);
					p.result_day = 5'(rest + 1);
				end
			end
		end
		p.dates_equal = (by == oy && bm == om && bd == od);
		p.base_later = (by > oy) || (by == oy && (bm > om || (bm == om && bd > od)));
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// Source side: bursts of transactions with random gaps between them.
	// ------------------------------------------------------------------------

	task automatic send_date(input date_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 6);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, r.other_day, r.other_month, r.other_year, r.day_offset,
			r.base_day, r.base_month, r.base_year};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		pending_results.push_back(predict_date_result(r));
		burst_left--;
	endtask

	function automatic date_req_t make_date(input int by, input int bm, input int bd,
		input int off, input int oy, input int om, input int od);
		date_req_t r;
		r.base_year = 12'(by);
		r.base_month = 4'(bm);
		r.base_day = 5'(bd);
		r.day_offset = 17'(off);
		r.other_year = 12'(oy);
		r.other_month = 4'(om);
		r.other_day = 5'(od);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Sink side: ready follows a rotating pattern that changes now and then.
	// ------------------------------------------------------------------------

	logic [7:0] ready_pattern;

	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) begin
			case ($urandom_range(0, 3))
				0:       ready_pattern = 8'hFF;
				1:       ready_pattern = 8'h01;
				default: ready_pattern = 8'($urandom) | 8'h01;
			endcase
		end
		m_tready <= ready_pattern[0];
		ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
	end

	// ------------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		date_rsp_t got;
		date_rsp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.result_year = m_tdata[11:0];
			got.result_month = m_tdata[15:12];
			got.result_day = m_tdata[20:16];
			got.days_between = m_tdata[42:21];
			got.base_later = m_tdata[43];
			got.dates_equal = m_tdata[44];
			got.status = m_tuser[1:0];
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_MAX) begin
					$display("%t: unexpected result transaction, tdata=%h tuser=%h",
						$realtime, m_tdata, m_tuser);
				end
			end else begin
				want = pending_results.pop_front();
				if (got.result_year !== want.result_year
						|| got.result_month !== want.result_month
						|| got.result_day !== want.result_day
						|| got.days_between !== want.days_between
						|| got.base_later !== want.base_later
						|| got.dates_equal !== want.dates_equal
						|| got.status !== want.status) begin
					error_count++;
					if (error_count <= REPORT_MAX) begin
						$display("%t: mismatch, expected date %0d-%0d-%0d diff %0d later %0b equal %0b status %0d",
							$realtime, want.result_year, want.result_month, want.result_day,
							want.days_between, want.base_later, want.dates_equal, want.status);
						$display("%t:           actual date %0d-%0d-%0d diff %0d later %0b equal %0b status %0d",
							$realtime, got.result_year, got.result_month, got.result_day,
							got.days_between, got.base_later, got.dates_equal, got.status);
					end
				end
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Smallest and largest years, offsets and dates.
	task automatic test_field_extremes();
		send_date(make_date(0, 1, 1, 0, 0, 1, 1));
		send_date(make_date(4095, 12, 31, 0, 4095, 12, 31));
		send_date(make_date(2000, 2, 29, 65535, 1, 1, 1));
		send_date(make_date(2000, 3, 1, -65536, 4095, 12, 31));
		send_date(make_date(4095, 1, 1, -65535, 0, 12, 31));
	endtask

	// Bad month codes, day zero, day past the month end and leap day checks.
	task automatic test_invalid_base_date();
		send_date(make_date(2024, 0, 31, 10, 2024, 1, 1));
		send_date(make_date(1999, 13, 15, -10, 2000, 1, 1));
		send_date(make_date(3000, 15, 31, 100, 3000, 12, 31));
		send_date(make_date(1500, 6, 0, 1, 1500, 6, 1));
		send_date(make_date(1900, 2, 29, 1, 1900, 3, 1));
		send_date(make_date(2023, 4, 31, 1, 2023, 5, 1));
		send_date(make_date(2024, 2, 29, 365, 2024, 2, 28));
		send_date(make_date(0, 2, 29, -59, 0, 3, 1));
	endtask

	// Shifted year leaving the calendar range, and year carries and borrows.
	task automatic test_shift_range();
		send_date(make_date(0, 1, 1, -1, 0, 1, 2));
		send_date(make_date(4095, 12, 31, 1, 4094, 1, 1));
		send_date(make_date(4095, 12, 31, -365, 1, 1, 1));
		send_date(make_date(3999, 12, 31, 1, 4000, 1, 1));
		send_date(make_date(2100, 3, 1, -1, 2100, 2, 28));
	endtask

	// Field-wise ordering of the two dates and the raw day count of odd dates.
	task automatic test_compare_flags();
		send_date(make_date(2020, 5, 1, 30, 2020, 4, 30));
		send_date(make_date(2020, 5, 2, -30, 2020, 5, 1));
		send_date(make_date(2019, 12, 31, 1, 2020, 1, 1));
		send_date(make_date(2020, 5, 1, 0, 2020, 5, 2));
		send_date(make_date(2020, 2, 31, 0, 2020, 3, 2));
	endtask

	function automatic int random_year();
		case ($urandom_range(0, 4))
			0:       return $urandom_range(0, 200);
			1:       return $urandom_range(3900, 4095);
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	// Mostly valid base dates with random offsets, some raw field noise.
	task automatic test_random_dates();
		int by;
		int bm;
		int bd;
		int off;
		int oy;
		int om;
		int od;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			by = random_year();
			if ($urandom_range(0, 7) == 0) begin
				bm = $urandom_range(0, 15);
				bd = $urandom_range(0, 31);
			end else begin
				bm = $urandom_range(1, 12);
				bd = $urandom_range(1, month_length(by, bm));
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: off = int'($urandom_range(0, 800)) - 400;
				4, 5, 6:    off = int'($urandom_range(0, 20000)) - 10000;
				default:    off = int'($urandom_range(0, 131071)) - 65536;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					oy = by;
					om = (bm >= 1 && bm <= 12) ? bm : 1;
					od = (bd >= 1) ? bd : 1;
				end
				3, 4, 5: begin
					oy = by;
					om = $urandom_range(1, 12);
					od = $urandom_range(1, 31);
				end
				default: begin
					oy = random_year();
					om = $urandom_range(1, 12);
					od = $urandom_range(1, 31);
				end
			endcase
			send_date(make_date(by, bm, bd, off, oy, om, od));
		end
		s_tvalid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		ready_pattern = 8'hFF;
		error_count = 0;
		burst_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_invalid_base_date();
		test_shift_range();
		test_compare_flags();
		test_random_dates();

		// Let every expected result arrive, then watch for strays.
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			error_count++;
		end

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
